>>> rtl/core/optical_flow_velocity_odometry_top_macros.svh
// Assertion macros shared by the optical-flow odometry RTL.
`ifndef OPTICAL_FLOW_VELOCITY_ODOMETRY_TOP_MACROS_SVH
`define OPTICAL_FLOW_VELOCITY_ODOMETRY_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OFVO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OFVO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ofvo_pkg.sv
// Package with widths, constants, state and command types of the odometry block.
`timescale 1ns / 1ps
package ofvo_pkg;

    localparam int OFVO_WINDOW = 8;

    localparam int FLOW_W = 16;
    localparam int DIST_W = 16;
    localparam int SPAN_W = 32;
    localparam int QUAL_W = 8;
    localparam int VEL_W  = 32;
    localparam int ACC_W  = 48;
    localparam int IN_W   = 2 * FLOW_W + DIST_W + SPAN_W + QUAL_W;
    localparam int OUT_W  = 2 * VEL_W + 2 * ACC_W;

    // |flow * distance| fits in 31 bits; shifted left by 16 for Q15.16.
    localparam int PMAG_W = 2 * FLOW_W - 1;
    localparam int DVD_W  = PMAG_W + 16;
    // 10 * span needs 36 bits.
    localparam int DVS_W  = SPAN_W + 4;

    // Limit test: v * 1e8 < 98304 * distance, exact in 60 bits.
    localparam int LIM_W = 60;
    localparam logic signed [27:0] LIM_V_K = 28'sd100000000;
    localparam logic signed [17:0] LIM_D_K = 18'sd98304;

    localparam logic [QUAL_W-1:0] QTHR_RESET = 8'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_AXIS,
        ST_MUL,
        ST_VDIV,
        ST_VWAIT,
        ST_LMUL,
        ST_LCMP,
        ST_UPD,
        ST_ADIV,
        ST_AWAIT,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic axis;
        logic mul;
        logic div_vel;
        logic vel_take;
        logic lim_mul;
        logic update;
        logic div_avg;
        logic avg_take;
        logic accum;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic qual_pass;
        logic span_zero;
        logic take;
        logic div_done;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/ofvo_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ofvo_div
    import ofvo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot,
    output logic             o_done,
    output logic             o_busy
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_diff;

    assign w_sh   = {r_rem, r_q[DVD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            if (!w_diff[DVS_W]) begin
                r_rem <= w_diff[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
    assign o_busy = (r_cnt != '0);

endmodule

>>> rtl/core/ofvo_dp.sv
// Datapath: input latch, velocity, limit test, ring window, accumulators, output register.
`timescale 1ns / 1ps
module ofvo_dp
    import ofvo_pkg::*;
#(
    parameter int WINDOW = OFVO_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_W-1:0]   i_in_data,
    input  logic [QUAL_W-1:0] i_qthr,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,
    output logic [1:0]        o_m_tuser
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = VEL_W + $clog2(WINDOW);
    localparam int ADDR_W = SLOT_W + 1;

    logic signed [FLOW_W-1:0] r_fx, r_fy;
    logic signed [DIST_W-1:0] r_dist;
    logic [SPAN_W-1:0]        r_span;
    logic [QUAL_W-1:0]        r_qual;

    logic                     r_pneg;
    logic [PMAG_W-1:0]        r_pmag;
    logic signed [VEL_W-1:0]  r_v;
    logic signed [LIM_W-1:0]  r_lhs, r_rhs;
    logic signed [VEL_W-1:0]  r_rd;

    logic signed [SUM_W-1:0]  r_sum  [2];
    logic [SLOT_W-1:0]        r_slot [2];
    logic [FILL_W-1:0]        r_fill [2];
    logic signed [ACC_W-1:0]  r_acc  [2];
    logic signed [VEL_W-1:0]  r_avg  [2];
    logic [1:0]               r_took;

    logic signed [VEL_W-1:0]  r_mem [2**ADDR_W];

    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;
    logic [1:0]               r_out_user;

    logic                     w_ax;
    logic signed [FLOW_W-1:0] w_flow;
    logic signed [2*FLOW_W-1:0] w_prod;
    logic [2*FLOW_W-1:0]      w_pabs;
    logic [DVS_W-1:0]         w_span10;
    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]         w_sabs;
    logic [DVD_W-1:0]         w_dvd;
    logic [DVS_W-1:0]         w_dvs;
    logic [DVD_W-1:0]         w_quot;
    logic                     w_done, w_busy;
    logic signed [VEL_W-1:0]  w_vsat;
    logic [VEL_W-1:0]         w_q32;
    logic signed [VEL_W-1:0]  w_old;
    logic signed [ACC_W:0]    w_acc_sum;
    logic signed [ACC_W-1:0]  w_acc_sat;
    logic [ADDR_W-1:0]        w_addr;
    logic                     w_out_free;

    assign w_ax     = i_cmd.axis;
    assign w_flow   = w_ax ? r_fy : r_fx;
    assign w_prod   = w_flow * r_dist;
    assign w_pabs   = w_prod[2*FLOW_W-1] ? (-w_prod) : w_prod;
    assign w_span10 = ({4'b0, r_span} << 3) + ({4'b0, r_span} << 1);
    assign w_sum    = r_sum[w_ax];
    assign w_sabs   = w_sum[SUM_W-1] ? (-w_sum) : w_sum;
    assign w_addr   = {w_ax, r_slot[w_ax]};

    assign w_dvd = i_cmd.div_vel ? {r_pmag, 16'b0} : DVD_W'(w_sabs);
    assign w_dvs = i_cmd.div_vel ? w_span10 : DVS_W'(r_fill[w_ax]);

    ofvo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_vel | i_cmd.div_avg),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_quot     (w_quot),
        .o_done     (w_done),
        .o_busy     (w_busy)
    );

    // Saturate the velocity quotient to the signed 32-bit range.
    always_comb begin
        if (r_pneg) begin
            if (w_quot > DVD_W'(33'h080000000)) begin
                w_vsat = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                w_vsat = -$signed(w_quot[VEL_W-1:0]);
            end
        end else begin
            if (w_quot > DVD_W'(32'h7FFFFFFF)) begin
                w_vsat = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
                w_vsat = $signed(w_quot[VEL_W-1:0]);
            end
        end
    end

    assign w_q32 = w_quot[VEL_W-1:0];
    assign w_old = (r_fill[w_ax] == FILL_W'(WINDOW)) ? r_rd : '0;

    assign w_acc_sum = (ACC_W+1)'(r_acc[w_ax]) + (ACC_W+1)'(r_avg[w_ax]);
    always_comb begin
        if (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]) begin
            w_acc_sat = w_acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_acc_sum[ACC_W-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fx   <= i_in_data[FLOW_W-1:0];
            r_fy   <= i_in_data[2*FLOW_W-1:FLOW_W];
            r_dist <= i_in_data[2*FLOW_W+DIST_W-1:2*FLOW_W];
            r_span <= i_in_data[2*FLOW_W+DIST_W+SPAN_W-1:2*FLOW_W+DIST_W];
            r_qual <= i_in_data[IN_W-1:IN_W-QUAL_W];
        end
        if (i_cmd.mul) begin
            r_pneg <= w_prod[2*FLOW_W-1];
            r_pmag <= w_pabs[PMAG_W-1:0];
        end
        if (i_cmd.vel_take) begin
            r_v <= w_vsat;
        end
        if (i_cmd.lim_mul) begin
            r_lhs <= LIM_W'(r_v) * LIM_W'(LIM_V_K);
            r_rhs <= LIM_W'(r_dist) * LIM_W'(LIM_D_K);
            r_rd  <= r_mem[w_addr];
        end
        if (i_cmd.update) begin
            r_mem[w_addr] <= r_v;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_acc[1], r_acc[0], r_avg[1], r_avg[0]};
            r_out_user <= r_took;
        end
    end

    // Per-axis window and accumulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_sum[i]  <= '0;
                r_slot[i] <= '0;
                r_fill[i] <= '0;
                r_acc[i]  <= '0;
                r_avg[i]  <= '0;
            end
            r_took      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_took <= '0;
            end
            if (i_cmd.update) begin
                r_sum[w_ax] <= w_sum - SUM_W'(w_old) + SUM_W'(r_v);
                r_slot[w_ax] <= (r_slot[w_ax] == SLOT_W'(WINDOW - 1)) ? '0
                              : r_slot[w_ax] + SLOT_W'(1);
                if (r_fill[w_ax] < FILL_W'(WINDOW)) begin
                    r_fill[w_ax] <= r_fill[w_ax] + FILL_W'(1);
                end
                r_took[w_ax] <= 1'b1;
            end
            if (i_cmd.avg_take) begin
                if (r_fill[w_ax] == '0) begin
                    r_avg[w_ax] <= '0;
                end else if (w_sum[SUM_W-1]) begin
                    r_avg[w_ax] <= -$signed(w_q32);
                end else begin
                    r_avg[w_ax] <= $signed(w_q32);
                end
            end
            if (i_cmd.accum && r_took[w_ax]) begin
                r_acc[w_ax] <= w_acc_sat;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_stat.qual_pass = (r_qual > i_qthr);
    assign o_stat.span_zero = (r_span == '0);
    assign o_stat.take      = (r_lhs < r_rhs);
    assign o_stat.div_done  = w_done;
    assign o_stat.div_busy  = w_busy;
    assign o_stat.out_free  = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

>>> rtl/core/ofvo_ctrl.sv
// Controller state machine that sequences both axes through the shared datapath.
`timescale 1ns / 1ps
`include "optical_flow_velocity_odometry_top_macros.svh"
module ofvo_ctrl
    import ofvo_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                n_axis = 1'b0;
                if (i_s_tvalid) n_state = ST_CHECK;
            end
            ST_CHECK: n_state = i_stat.qual_pass ? ST_AXIS : ST_IDLE;
            ST_AXIS:  n_state = i_stat.span_zero ? ST_ADIV : ST_MUL;
            ST_MUL:   n_state = ST_VDIV;
            ST_VDIV:  n_state = ST_VWAIT;
            ST_VWAIT: if (i_stat.div_done) n_state = ST_LMUL;
            ST_LMUL:  n_state = ST_LCMP;
            ST_LCMP:  n_state = i_stat.take ? ST_UPD : ST_ADIV;
            ST_UPD:   n_state = ST_ADIV;
            ST_ADIV:  n_state = ST_AWAIT;
            ST_AWAIT: if (i_stat.div_done) n_state = ST_ACC;
            ST_ACC: begin
                if (r_axis) begin
                    n_state = ST_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = ST_AXIS;
                end
            end
            ST_OUT:   if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            ST_MUL:   o_cmd.mul      = 1'b1;
            ST_VDIV:  o_cmd.div_vel  = 1'b1;
            ST_VWAIT: o_cmd.vel_take = i_stat.div_done;
            ST_LMUL:  o_cmd.lim_mul  = 1'b1;
            ST_UPD:   o_cmd.update   = 1'b1;
            ST_ADIV:  o_cmd.div_avg  = 1'b1;
            ST_AWAIT: o_cmd.avg_take = i_stat.div_done;
            ST_ACC:   o_cmd.accum    = 1'b1;
            ST_OUT:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    `OFVO_ASSERT_IMPL(a_done_when_waiting, i_stat.div_done, (r_state == ST_VWAIT || r_state == ST_AWAIT), "divider finished outside a wait state")
    `OFVO_ASSERT_IMPL(a_idle_div_free, r_state == ST_IDLE, !i_stat.div_busy, "divider busy while idle")
    `OFVO_ASSERT_IMPL(a_load_needs_room, o_cmd.out_load, i_stat.out_free, "result loaded over an untaken beat")
    `OFVO_ASSERT_NEXT(a_start_makes_busy, o_cmd.div_vel || o_cmd.div_avg, i_stat.div_busy, "divider did not start")

endmodule

>>> rtl/core/optical_flow_velocity_odometry_top.sv
// Top level of the optical-flow velocity odometry block.
`timescale 1ns / 1ps
// Each input beat carries one integrated optical-flow frame. A frame whose
// quality is not above the quality_threshold register (APB address 0, reset
// 100) is dropped and produces no output beat. Any other frame produces one
// output beat with both window averages, both saturating totals and the two
// took flags. Frames are processed one at a time: the x axis and then the y
// axis go through the velocity divide and the exact limit test (both skipped
// at zero span), the ring-window update (only when the limit passes) and the
// average divide, all on one shared restoring divider that retires one
// quotient bit per cycle over a 47-bit dividend. The input is taken again as
// soon as the previous frame is handed to the output register, even if that
// beat is still waiting for the sink. The ring entries live in a small
// memory that needs no clearing pass after reset; entries not yet written
// may be read but their data is never used.
module optical_flow_velocity_odometry_top
    import ofvo_pkg::*;
#(
    parameter int WINDOW = OFVO_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input frame beat.
    input  logic              s_tvalid,
    output logic              s_tready,
    // tdata from bit 0: flow_x[15:0], flow_y[31:16], ground_mm[47:32],
    // span_us[79:48], frame_quality[87:80].
    input  logic [IN_W-1:0]   s_tdata,
    // Result beat.
    output logic              m_tvalid,
    input  logic              m_tready,
    // tdata from bit 0: avg_x[31:0], avg_y[63:32], total_x[111:64],
    // total_y[159:112].
    output logic [OUT_W-1:0]  m_tdata,
    // tuser from bit 0: took_x, took_y.
    output logic [1:0]        m_tuser,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // The only register is at byte address 0; bit 2 selects past it.
    logic [QUAL_W-1:0] r_qthr;
    t_cmd              w_cmd;
    t_stat             w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qthr <= QTHR_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_qthr <= pwdata[QUAL_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-QUAL_W){1'b0}}, r_qthr};

    ofvo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ofvo_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (s_tdata),
        .i_qthr     (r_qthr),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

>>> bench/tb_optical_flow_velocity_odometry_top.sv
// Self-checking testbench for the optical-flow velocity odometry top level.
`timescale 1ns / 1ps
// Frames are queued by the stimulus process and offered by a clocked driver.
// Each accepted frame is run through a local model of the velocity divide,
// the limit test, the ring-window average and the saturating totals. Each
// output beat is checked against the oldest predicted result. The quality
// threshold is rewritten between phases, only while the block is idle.
module tb_optical_flow_velocity_odometry_top;
    import ofvo_pkg::*;

    typedef struct {
        logic signed [31:0] avg_x;
        logic signed [31:0] avg_y;
        logic signed [47:0] total_x;
        logic signed [47:0] total_y;
        logic               took_x;
        logic               took_y;
    } t_odo_result;

    localparam longint SAT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT48_LO = -SAT48_HI - 1;
    // Settling margin that covers one frame still in flight.
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 3000;
    localparam int HOLD_AT_BEAT  = 200;
    localparam logic [2:0] ADDR_QTHR = 3'd0;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // Fields from bit 0: flow_x, flow_y, ground_mm, span_us, frame_quality.
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // Fields from bit 0: avg_x, avg_y, total_x, total_y.
    logic [OUT_W-1:0]  m_tdata;
    // Fields from bit 0: took_x, took_y.
    logic [1:0]        m_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Frames waiting to be offered, and results the block still owes us.
    logic [IN_W-1:0]   frame_queue[$];
    t_odo_result       owed_results[$];

    // Local copy of the block state: index 0 is x, index 1 is y.
    int                ring_vel[2][OFVO_WINDOW];
    longint            win_sum[2];
    int                ring_slot[2];
    int                ring_fill[2];
    longint            total_acc[2];
    logic [7:0]        qual_thr;

    int                fail_count;
    int                frames_taken;
    int                hold_left;
    bit                hold_done;
    // 0: sender idles 27%, receiver 47%. 1: the reverse. 2: no idling.
    int                idle_mode;

    optical_flow_velocity_odometry_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Velocity in Q15.16, rounded toward zero and saturated to 32 bits.
    function automatic int flow_velocity(longint flow, longint ground, longint unsigned span);
        longint          prod;
        bit              neg;
        longint unsigned mag;
        longint unsigned quo;
        prod = flow * ground;
        neg  = prod < 0;
        mag  = longint'(neg ? -prod : prod) << 16;
        quo  = mag / (64'd10 * span);
        if (neg) begin
            if (quo > 64'h8000_0000) quo = 64'h8000_0000;
            return int'(-longint'(quo));
        end
        if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
        return int'(quo);
    endfunction

    function automatic int window_mean(int ax);
        if (ring_fill[ax] == 0) return 0;
        return int'(win_sum[ax] / longint'(ring_fill[ax]));
    endfunction

    // Advances one axis; returns whether its velocity passed the limit.
    function automatic bit advance_axis(int ax, longint flow, longint ground,
                                        longint unsigned span);
        int     vel;
        longint acc;
        if (span == 0) return 1'b0;
        vel = flow_velocity(flow, ground, span);
        // Exact form of v < 1.5 * distance / 1e8 with v in Q15.16.
        if (!(longint'(vel) * 100000000 < 98304 * ground)) return 1'b0;
        win_sum[ax] = win_sum[ax] - ring_vel[ax][ring_slot[ax]] + vel;
        ring_vel[ax][ring_slot[ax]] = vel;
        ring_slot[ax] = (ring_slot[ax] + 1 >= OFVO_WINDOW) ? 0 : ring_slot[ax] + 1;
        if (ring_fill[ax] < OFVO_WINDOW) ring_fill[ax]++;
        acc = total_acc[ax] + window_mean(ax);
        if (acc > SAT48_HI) acc = SAT48_HI;
        if (acc < SAT48_LO) acc = SAT48_LO;
        total_acc[ax] = acc;
        return 1'b1;
    endfunction

    // Runs one accepted frame through the model and queues its result, if any.
    function automatic void predict_frame(logic [IN_W-1:0] beat);
        t_odo_result     res;
        longint          fx;
        longint          fy;
        longint          ground;
        longint unsigned span;
        fx     = longint'($signed(beat[15:0]));
        fy     = longint'($signed(beat[31:16]));
        ground = longint'($signed(beat[47:32]));
        span   = longint'(beat[79:48]);
        // Frames at or below the threshold leave no trace.
        if (beat[87:80] <= qual_thr) return;
        res.took_x  = advance_axis(0, fx, ground, span);
        res.took_y  = advance_axis(1, fy, ground, span);
        res.avg_x   = window_mean(0);
        res.avg_y   = window_mean(1);
        res.total_x = total_acc[0][47:0];
        res.total_y = total_acc[1][47:0];
        owed_results.push_back(res);
    endfunction

    function automatic logic [IN_W-1:0] pack_frame(logic [15:0] fx, logic [15:0] fy,
                                                   logic [15:0] ground, logic [31:0] span,
                                                   logic [7:0] qual);
        return {qual, span, ground, fy, fx};
    endfunction

    function automatic int urandom_range_wrap();
        return $urandom_range(0, 255);
    endfunction

    // Mostly plausible frames: small flow, positive height and long spans so
    // that the limit test passes often. The rest is raw noise over all bits.
    function automatic logic [IN_W-1:0] random_frame();
        logic [7:0]  qual;
        logic [31:0] span;
        int          amp;
        if ($urandom_range(99) < 15)
            return pack_frame(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                              8'($urandom));
        qual = (qual_thr == 8'hFF) ? 8'(urandom_range_wrap()) :
               8'($urandom_range(int'(qual_thr) + 1, 255));
        if ($urandom_range(99) < 8) qual = 8'($urandom_range(0, qual_thr));
        span = ($urandom_range(99) < 4) ? 32'd0 : $urandom;
        amp  = 1 << $urandom_range(0, 8);
        return pack_frame(16'($urandom_range(0, 2 * amp) - amp),
                          16'($urandom_range(0, 2 * amp) - amp),
                          ($urandom_range(99) < 10) ? 16'($urandom) :
                              16'($urandom_range(1, 5000)),
                          span, qual);
    endfunction

    // Sender: holds a beat until it is taken, then offers the next one.
    always @(posedge i_clk) begin : frame_driver
        int  idle_pct;
        bit  taken;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            idle_pct = (idle_mode == 0) ? 27 : (idle_mode == 1) ? 47 : 0;
            taken = s_tvalid && s_tready;
            if (taken) begin
                predict_frame(s_tdata);
                void'(frame_queue.pop_front());
                frames_taken <= frames_taken + 1;
            end
            if (s_tvalid && !taken) begin
                s_tvalid <= 1'b1;
            end else if (frame_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= frame_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long sink stall so the block fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && frames_taken == HOLD_AT_BEAT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        int          idle_pct;
        t_odo_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            idle_pct = (idle_mode == 0) ? 47 : (idle_mode == 1) ? 27 : 0;
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with none expected: tdata=%h tuser=%b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[31:0] !== want.avg_x) begin
                        $display("%0t: avg_x expected %0d actual %0d", $time,
                                 want.avg_x, $signed(m_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== want.avg_y) begin
                        $display("%0t: avg_y expected %0d actual %0d", $time,
                                 want.avg_y, $signed(m_tdata[63:32]));
                        fail_count++;
                    end
                    if (m_tdata[111:64] !== want.total_x) begin
                        $display("%0t: total_x expected %0d actual %0d", $time,
                                 want.total_x, $signed(m_tdata[111:64]));
                        fail_count++;
                    end
                    if (m_tdata[159:112] !== want.total_y) begin
                        $display("%0t: total_y expected %0d actual %0d", $time,
                                 want.total_y, $signed(m_tdata[159:112]));
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.took_x) begin
                        $display("%0t: took_x expected %b actual %b", $time,
                                 want.took_x, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.took_y) begin
                        $display("%0t: took_y expected %b actual %b", $time,
                                 want.took_y, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
        end
    end

    // APB register write in setup and access phases; the model copy follows once it has landed.
    task automatic write_threshold(logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_QTHR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        qual_thr = value;
    endtask

    // Waits until every frame is taken and every result has come back, then
    // lets a dropped frame still in flight finish.
    task automatic wait_idle();
        while (frame_queue.size() > 0 || s_tvalid || owed_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) frame_queue.push_back(random_frame());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        fail_count   = 0;
        frames_taken = 0;
        idle_mode    = 0;
        qual_thr     = QTHR_RESET;
        for (int ax = 0; ax < 2; ax++) begin
            win_sum[ax]   = 0;
            ring_slot[ax] = 0;
            ring_fill[ax] = 0;
            total_acc[ax] = 0;
            for (int k = 0; k < OFVO_WINDOW; k++) ring_vel[ax][k] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset threshold of 100: quality on both
        // sides of it, zero span, extreme flow and height, negative height.
        frame_queue.push_back(pack_frame(16'd5, 16'd5, 16'd1000, 32'd40000000, 8'd100));
        frame_queue.push_back(pack_frame(16'd5, 16'd5, 16'd1000, 32'd40000000, 8'd0));
        frame_queue.push_back(pack_frame(16'd5, -16'sd5, 16'd1000, 32'd40000000, 8'd101));
        frame_queue.push_back(pack_frame(16'd7, 16'd9, 16'd1000, 32'd0, 8'd255));
        frame_queue.push_back(pack_frame(16'h7FFF, 16'h8000, 16'h7FFF, 32'd1, 8'd200));
        frame_queue.push_back(pack_frame(16'h8000, 16'h8000, 16'h8000, 32'd1, 8'd200));
        frame_queue.push_back(pack_frame(16'h8000, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 8'd150));
        frame_queue.push_back(pack_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 8'd150));
        frame_queue.push_back(pack_frame(16'd3, -16'sd3, -16'sd500, 32'd90000000, 8'd180));
        frame_queue.push_back(pack_frame(-16'sd3, 16'd3, -16'sd1, 32'd1000, 8'd180));
        frame_queue.push_back(pack_frame(16'd0, 16'd0, 16'd0, 32'd100, 8'd180));
        frame_queue.push_back(pack_frame(16'd1, 16'd1, 16'd0, 32'd100, 8'd180));
        // Enough used samples on both axes to wrap the ring window.
        for (int k = 0; k < 11; k++)
            frame_queue.push_back(pack_frame(16'(k - 5), 16'(3 - k), 16'd2000,
                                             32'd400000000 + k, 8'd220));
        wait_idle();

        write_threshold(8'd0);
        queue_random(450);
        wait_idle();

        idle_mode = 1;
        write_threshold(8'd200);
        queue_random(380);
        wait_idle();

        // Highest threshold: every frame is dropped.
        write_threshold(8'd255);
        queue_random(20);
        wait_idle();

        idle_mode = 2;
        write_threshold(8'($urandom_range(1, 254)));
        queue_random(420);
        wait_idle();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
